// ===== rtl/drn_pkg.sv =====
// ----------------------------------------------------------------------------
// drn_pkg - shared types and constants for the director rotate/normalize core
// Word layouts, CORDIC datapath widths and the arctangent table.
// ----------------------------------------------------------------------------
package drn_pkg;

   localparam int DirWidth    = 18;
   localparam int AngleWidth  = 16;
   localparam int CordWidth   = 34;   // Q2.30 plus growth headroom
   localparam int TableLen    = 31;
   localparam int InScaleBits = 12;
   localparam int DefFracBits = 16;
   localparam int DefSteps    = 16;

   localparam int ReqDataWidth = 56;  // 52 used bits, padded to bytes
   localparam int RspDataWidth = 40;  // 36 used bits, padded to bytes

   localparam logic signed [CordWidth-1:0] InvGainQ30 = 34'sd652032874;

   localparam logic [0:0] AddrApplyAll = 1'b0;

   typedef struct packed {
      logic                        sel;
      logic                        zero;
      logic signed [DirWidth-1:0]  orig_x;
      logic signed [DirWidth-1:0]  orig_y;
      logic [AngleWidth-1:0]       angle;
   } side_type;

   function automatic logic [31:0] atan_turns(input int idx);
      logic [31:0] val;
      case (idx)
         0:  val = 32'h20000000;
         1:  val = 32'h12E4051E;
         2:  val = 32'h09FB385B;
         3:  val = 32'h051111D4;
         4:  val = 32'h028B0D43;
         5:  val = 32'h0145D7E1;
         6:  val = 32'h00A2F61E;
         7:  val = 32'h00517C55;
         8:  val = 32'h0028BE53;
         9:  val = 32'h00145F2F;
         10: val = 32'h000A2F98;
         11: val = 32'h000517CC;
         12: val = 32'h00028BE6;
         13: val = 32'h000145F3;
         14: val = 32'h0000A2FA;
         15: val = 32'h0000517D;
         16: val = 32'h000028BE;
         17: val = 32'h0000145F;
         18: val = 32'h00000A30;
         19: val = 32'h00000518;
         20: val = 32'h0000028C;
         21: val = 32'h00000146;
         22: val = 32'h000000A3;
         23: val = 32'h00000051;
         24: val = 32'h00000029;
         25: val = 32'h00000014;
         26: val = 32'h0000000A;
         27: val = 32'h00000005;
         28: val = 32'h00000003;
         29: val = 32'h00000001;
         30: val = 32'h00000001;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/director_rotate_normalize_core.sv =====
// ----------------------------------------------------------------------------
// director_rotate_normalize_core - rotate a 2D director and renormalize it
// Pipelined vectoring CORDIC, angle add, then rotation CORDIC to unit length.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one word per particle: director x/y (Q2.16) and an angle
//  (pi/32768 units) in tdata, the group flag in tuser. rsp_* returns one word
//  per request in the same order: new x/y in tdata, applied/zero_length flags
//  in tuser. csr_* is an APB port with one register, apply_to_all at 0x0
//  (reset 1); write it only while the pipe is empty.
//  Stages in order: one entry stage, one cell per vectoring step, one
//  angle fold stage, one cell per rotation step, one rounding/output
//  stage. While the output is not stalled, throughput is one word per
//  cycle and every cell of the chain hands its word to the next one.
//  The whole chain moves together: when the output holds a word that is not
//  taken, the chain and req_tready stall until rsp_tready returns.
//  Reset clears all stage valid bits and sets apply_to_all.
// ----------------------------------------------------------------------------
module director_rotate_normalize_core #(
   parameter int FRAC_BITS      = drn_pkg::DefFracBits,
   parameter int ROTATION_STEPS = drn_pkg::DefSteps
) (
   input  logic                              clock,
   input  logic                              reset,
   // tdata: dir_x[17:0], dir_y[35:18], angle[51:36], zero pad
   input  logic [drn_pkg::ReqDataWidth-1:0]  req_tdata,
   // tuser: in_group[0]
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: new_dir_x[17:0], new_dir_y[35:18], zero pad
   output logic [drn_pkg::RspDataWidth-1:0]  rsp_tdata,
   // tuser: applied[0], zero_length[1]
   output logic [1:0]                        rsp_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [0:0]                        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import drn_pkg::*;

   localparam int Steps    = (ROTATION_STEPS < TableLen) ? ROTATION_STEPS : TableLen;
   localparam int OutShift = 30 - FRAC_BITS;
   localparam logic signed [CordWidth:0] RndAdd =
      (OutShift > 0) ? (CordWidth+1)'(1) <<< (OutShift - 1) : '0;
   localparam logic signed [CordWidth:0] OutMax = (CordWidth+1)'(131071);
   localparam logic signed [CordWidth:0] OutMin = -(CordWidth+1)'(131072);

   // ---- configuration register
   logic apply_ff;
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         apply_ff <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == AddrApplyAll) begin
         apply_ff <= csr_pwdata[0];
      end
   end
   assign csr_prdata = (csr_paddr == AddrApplyAll) ? {31'b0, apply_ff} : 32'b0;

   // ---- chain advance: moves unless a finished word is waiting
   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // ---- entry stage: select, zero check, half-plane fold, scale
   logic signed [DirWidth-1:0]   dx, dy;
   logic signed [CordWidth-1:0]  ex, ey, ez;
   side_type                     eside;
   always_comb begin
      dx          = signed'(req_tdata[17:0]);
      dy          = signed'(req_tdata[35:18]);
      eside.sel   = apply_ff || req_tuser;
      eside.zero  = (dx == '0) && (dy == '0);
      eside.orig_x = dx;
      eside.orig_y = dy;
      eside.angle = req_tdata[51:36];
      ex = CordWidth'(dx);
      ey = CordWidth'(dy);
      ez = '0;
      if (dx < 0) begin
         ex = -ex;
         ey = -ey;
         ez = CordWidth'(35'sh080000000);
      end
      ex = ex <<< InScaleBits;
      ey = ey <<< InScaleBits;
   end

   logic                         v_vld [0:Steps];
   logic signed [CordWidth-1:0]  v_x [0:Steps], v_y [0:Steps], v_z [0:Steps];
   side_type                     v_side [0:Steps];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_vld[0] <= 1'b0;
      end else if (adv) begin
         v_vld[0] <= req_tvalid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         v_x[0]    <= ex;
         v_y[0]    <= ey;
         v_z[0]    <= ez;
         v_side[0] <= eside;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < Steps; gi++) begin : g_vec
         drn_cell #(.SHIFT(gi), .VECTORING(1'b1)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .adv     (adv),
            .in_vld  (v_vld[gi]),
            .in_x    (v_x[gi]),
            .in_y    (v_y[gi]),
            .in_z    (v_z[gi]),
            .in_side (v_side[gi]),
            .out_vld (v_vld[gi+1]),
            .out_x   (v_x[gi+1]),
            .out_y   (v_y[gi+1]),
            .out_z   (v_z[gi+1]),
            .out_side(v_side[gi+1])
         );
      end
   endgenerate

   // ---- fold stage: add rotation angle, map into +-pi/2
   logic [31:0]                  t;
   logic signed [CordWidth-1:0]  fx, fz;
   always_comb begin
      t  = v_z[Steps][31:0] + {v_side[Steps].angle, 16'b0};
      fx = InvGainQ30;
      if (t[31] != t[30]) begin
         t[31] = !t[31];
         fx    = -InvGainQ30;
      end
      fz = CordWidth'(signed'(t));
   end

   logic                         r_vld [0:Steps];
   logic signed [CordWidth-1:0]  r_x [0:Steps], r_y [0:Steps], r_z [0:Steps];
   side_type                     r_side [0:Steps];

   always_ff @(posedge clock) begin
      if (reset) begin
         r_vld[0] <= 1'b0;
      end else if (adv) begin
         r_vld[0] <= v_vld[Steps];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         r_x[0]    <= fx;
         r_y[0]    <= '0;
         r_z[0]    <= fz;
         r_side[0] <= v_side[Steps];
      end
   end

   generate
      for (gi = 0; gi < Steps; gi++) begin : g_rot
         drn_cell #(.SHIFT(gi), .VECTORING(1'b0)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .adv     (adv),
            .in_vld  (r_vld[gi]),
            .in_x    (r_x[gi]),
            .in_y    (r_y[gi]),
            .in_z    (r_z[gi]),
            .in_side (r_side[gi]),
            .out_vld (r_vld[gi+1]),
            .out_x   (r_x[gi+1]),
            .out_y   (r_y[gi+1]),
            .out_z   (r_z[gi+1]),
            .out_side(r_side[gi+1])
         );
      end
   endgenerate

   // ---- output stage: round half up, saturate, pick special cases
   logic signed [CordWidth:0]   qx, qy;
   logic signed [DirWidth-1:0]  ox_in, oy_in, ox_ff, oy_ff;
   logic                        appl_in, zl_in, appl_ff, zl_ff, ovld_ff;
   side_type                    fs;

   always_comb begin
      fs = r_side[Steps];
      qx = ((CordWidth+1)'(r_x[Steps]) + RndAdd) >>> OutShift;
      qy = ((CordWidth+1)'(r_y[Steps]) + RndAdd) >>> OutShift;
      if (qx > OutMax) qx = OutMax;
      if (qx < OutMin) qx = OutMin;
      if (qy > OutMax) qy = OutMax;
      if (qy < OutMin) qy = OutMin;
      if (!fs.sel) begin
         ox_in = fs.orig_x;  oy_in = fs.orig_y;  appl_in = 1'b0;  zl_in = 1'b0;
      end else if (fs.zero) begin
         ox_in = '0;  oy_in = '0;  appl_in = 1'b1;  zl_in = 1'b1;
      end else begin
         ox_in = qx[DirWidth-1:0];  oy_in = qy[DirWidth-1:0];
         appl_in = 1'b1;  zl_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
      end else if (adv) begin
         ovld_ff <= r_vld[Steps];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         ox_ff   <= ox_in;
         oy_ff   <= oy_in;
         appl_ff <= appl_in;
         zl_ff   <= zl_in;
      end
   end

   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = {4'b0, oy_ff, ox_ff};
   assign rsp_tuser  = {zl_ff, appl_ff};

   // ---- checks
   a_zero_applied: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("zero_length without applied");
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata[35:0] == '0)
      else $error("zero_length with nonzero vector");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("output word lost during stall");
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("valid after reset");

endmodule

// ===== rtl/drn_cell.sv =====
// ----------------------------------------------------------------------------
// drn_cell - one CORDIC micro-rotation stage
// Vectoring or rotation step at a fixed shift, registered, with sideband.
// ----------------------------------------------------------------------------
module drn_cell #(
   parameter int SHIFT     = 0,
   parameter bit VECTORING = 1'b1
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     adv,
   input  logic                                     in_vld,
   input  logic signed [drn_pkg::CordWidth-1:0]     in_x,
   input  logic signed [drn_pkg::CordWidth-1:0]     in_y,
   input  logic signed [drn_pkg::CordWidth-1:0]     in_z,
   input  drn_pkg::side_type                        in_side,
   output logic                                     out_vld,
   output logic signed [drn_pkg::CordWidth-1:0]     out_x,
   output logic signed [drn_pkg::CordWidth-1:0]     out_y,
   output logic signed [drn_pkg::CordWidth-1:0]     out_z,
   output drn_pkg::side_type                        out_side
);
   import drn_pkg::*;

   localparam logic signed [CordWidth-1:0] Atan =
      CordWidth'(signed'({1'b0, atan_turns(SHIFT)}));

   logic                         vld_ff;
   logic signed [CordWidth-1:0]  x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic signed [CordWidth-1:0]  sx, sy;
   side_type                     side_ff;
   logic                         ccw;

   always_comb begin
      sx  = in_x >>> SHIFT;
      sy  = in_y >>> SHIFT;
      // vectoring drives y to zero, rotation drives z to zero
      ccw = VECTORING ? in_y[CordWidth-1] : !in_z[CordWidth-1];
      if (ccw) begin
         x_in = in_x - sy;
         y_in = in_y + sx;
         z_in = in_z - Atan;
      end else begin
         x_in = in_x + sy;
         y_in = in_y - sx;
         z_in = in_z + Atan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_vld  = vld_ff;
   assign out_x    = x_ff;
   assign out_y    = y_ff;
   assign out_z    = z_ff;
   assign out_side = side_ff;

endmodule

// ===== tb/sv/drn_checker.sv =====
// ----------------------------------------------------------------------------
// drn_checker - result predictor and scoreboard for the director core
// Watches the req/rsp streams and the csr port, predicts each result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module drn_checker #(
   parameter int FRAC_BITS      = drn_pkg::DefFracBits,
   parameter int ROTATION_STEPS = drn_pkg::DefSteps
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [drn_pkg::ReqDataWidth-1:0]  req_tdata,
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [drn_pkg::RspDataWidth-1:0]  rsp_tdata,
   input  logic [1:0]                        rsp_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [0:0]                        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   input  logic                              csr_pready,
   output int                                fail_count,
   output int                                pending
);
   import drn_pkg::*;

   typedef struct packed {
      logic signed [DirWidth-1:0] nx;
      logic signed [DirWidth-1:0] ny;
      logic                       applied;
      logic                       zero_len;
   } dir_result_type;

   // own copy of the arctangent table, in 32-bit turns
   localparam logic [31:0] ATAN_TURNS [0:30] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001};

   logic           all_sel;
   dir_result_type expected_dirs[$];

   function automatic logic signed [DirWidth-1:0] round_sat(longint q30);
      longint r;
      int     sh;
      sh = 30 - FRAC_BITS;
      r  = (sh > 0) ? ((q30 + (64'sd1 <<< (sh - 1))) >>> sh) : q30;
      if (r > 131071) r = 131071;
      if (r < -131072) r = -131072;
      return r[DirWidth-1:0];
   endfunction

   function automatic dir_result_type rotate_dir(logic signed [DirWidth-1:0] dx,
         logic signed [DirWidth-1:0] dy, logic [AngleWidth-1:0] ang, logic grp);
      dir_result_type res;
      longint         x, y, z, ux, uy, zr, tx, ty;
      logic [31:0]    t;
      int             n;
      n = (ROTATION_STEPS < TableLen) ? ROTATION_STEPS : TableLen;
      if (!(all_sel || grp)) begin
         res = '{dx, dy, 1'b0, 1'b0};
         return res;
      end
      if (dx == 0 && dy == 0) begin
         res = '{'0, '0, 1'b1, 1'b1};
         return res;
      end
      x = dx; y = dy; z = 0;
      if (x < 0) begin   // left half-plane: fold over and add pi
         x = -x; y = -y; z = 64'h80000000;
      end
      x = x * 4096; y = y * 4096;
      for (int i = 0; i < n; i++) begin
         tx = y >>> i; ty = x >>> i;
         if (y < 0) begin
            x -= tx; y += ty; z -= ATAN_TURNS[i];
         end else begin
            x += tx; y -= ty; z += ATAN_TURNS[i];
         end
      end
      t  = z[31:0] + {ang, 16'h0};
      ux = 652032874; uy = 0;
      if (t[31:30] == 2'd1 || t[31:30] == 2'd2) begin
         t[31] = ~t[31]; ux = -ux;
      end
      zr = longint'($signed(t));
      for (int i = 0; i < n; i++) begin
         tx = uy >>> i; ty = ux >>> i;
         if (zr >= 0) begin
            ux -= tx; uy += ty; zr -= ATAN_TURNS[i];
         end else begin
            ux += tx; uy -= ty; zr += ATAN_TURNS[i];
         end
      end
      res = '{round_sat(ux), round_sat(uy), 1'b1, 1'b0};
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   assign pending = expected_dirs.size();

   always @(posedge clock) begin
      dir_result_type want;
      if (reset) begin
         all_sel <= 1'b1;
         expected_dirs.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
               && csr_paddr == AddrApplyAll)
            all_sel <= csr_pwdata[0];
         if (req_tvalid && req_tready)
            expected_dirs.push_back(rotate_dir(req_tdata[17:0], req_tdata[35:18],
                                               req_tdata[51:36], req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_dirs.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata[35:0], 0);
            end else begin
               want = expected_dirs.pop_front();
               if ($signed(rsp_tdata[17:0]) != want.nx)
                  report_mismatch("new_dir_x", $signed(rsp_tdata[17:0]), want.nx);
               if ($signed(rsp_tdata[35:18]) != want.ny)
                  report_mismatch("new_dir_y", $signed(rsp_tdata[35:18]), want.ny);
               if (rsp_tuser[0] != want.applied)
                  report_mismatch("applied", rsp_tuser[0], want.applied);
               if (rsp_tuser[1] != want.zero_len)
                  report_mismatch("zero_length", rsp_tuser[1], want.zero_len);
            end
         end
      end
   end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - stimulus and verdict for director_rotate_normalize_core
// Directed corners, then random directors with random stalls on both sides,
// a long receiver hold-off, and apply_to_all toggled between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import drn_pkg::*;

   localparam int LATENCY     = 2 * DefSteps + 3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic                    req_tuser = 1'b0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic [1:0]              rsp_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [0:0]              csr_paddr = '0;
   logic [31:0]             csr_pwdata = '0;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int sink_hold = 0;       // cycles of the long receiver hold-off so far
   bit hold_go = 1'b0;      // starts the long receiver hold-off
   bit sink_calm = 1'b0;    // no random stalls on the receiver

   director_rotate_normalize_core dut (.*);

   drn_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver: random stalls, or a hold-off once hold_go is raised
   always @(negedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else if (hold_go && sink_hold < HOLD_CYCLES) begin
         rsp_tready <= 1'b0;
         sink_hold  <= sink_hold + 1;
      end else
         rsp_tready <= sink_calm || ($urandom_range(99) >= 17);
   end

   // APB write: setup cycle, then access cycle
   task automatic csr_write(logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1;
      csr_paddr <= AddrApplyAll; csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   // offer one word, hold it until accepted; optional random gap first
   task automatic send_dir(logic [17:0] dx, logic [17:0] dy, logic [15:0] ang,
                           logic grp, bit gaps);
      while (gaps && $urandom_range(99) < 17) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= {4'b0, ang, dy, dx};
      req_tuser  <= grp;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // mostly unit-ish directors of random direction, some full-range noise
   task automatic send_random(int count, bit gaps);
      logic [17:0] dx, dy;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(9))
            0: begin dx = 18'($urandom); dy = 18'($urandom); end
            1: begin dx = 18'($urandom_range(15)); dy = 18'($urandom_range(15)); end
            2: begin dx = 18'h20000; dy = 18'($urandom); end
            default: begin
               dx = $signed(18'($urandom_range(131071))) - 18'sd65536;
               dy = $signed(18'($urandom_range(131071))) - 18'sd65536;
            end
         endcase
         if ($urandom_range(49) == 0) begin dx = '0; dy = '0; end
         send_dir(dx, dy, 16'($urandom), 1'($urandom), gaps);
      end
   endtask

   initial begin
      logic [17:0] ex [0:5];
      ex = '{18'h1FFFF, 18'h20000, 18'h00000, 18'h10000, 18'h30000, 18'h00001};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, zero director, left half-plane, wide and wrapped angles
      sink_calm = 1'b1;
      for (int i = 0; i < 6; i++)
         send_dir(ex[i], ex[5 - i], 16'h7FFF, 1'b0, 1'b0);
      send_dir(18'h0, 18'h0, 16'h1234, 1'b1, 1'b0);
      send_dir(18'h30000, 18'h00100, 16'h8000, 1'b1, 1'b0);
      send_dir(18'h10000, 18'h0, 16'h4000, 1'b0, 1'b0);
      send_dir(18'h10000, 18'h0, 16'hC000, 1'b0, 1'b0);
      send_dir(18'h20000, 18'h20000, 16'h0000, 1'b1, 1'b0);
      send_dir(18'h1FFFF, 18'h1FFFF, 16'hFFFF, 1'b1, 1'b0);
      drain();

      csr_write(32'h0);   // group members only
      for (int i = 0; i < 6; i++)
         send_dir(ex[i], ex[i], 16'h8000, i[0], 1'b0);
      send_dir(18'h0, 18'h0, 16'h0, 1'b1, 1'b0);
      send_dir(18'h0, 18'h0, 16'h0, 1'b0, 1'b0);
      sink_calm = 1'b0;
      send_random(200, 1'b1);
      drain();

      csr_write(32'hFFFF_FFFF);   // everyone, upper bits ignored
      // back-to-back with the receiver held off: pipe fills, req_tready drops
      hold_go = 1'b1;
      send_random(150, 1'b0);
      send_random(200, 1'b1);
      drain();

      csr_write(32'h1);
      sink_calm = 1'b1;           // long stretch with no stalls anywhere
      send_random(180, 1'b0);
      drain();

      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
